// ===== hw/rtl/wfhd_pkg.sv =====
// ============================================================================
// wfhd_pkg
// Shared widths, codes and types of the waveform Huffman delta decoder.
// ============================================================================
package wfhd_pkg;

    // Node index width is fixed by the stream format; the table covers every index.
    localparam int NODE_W       = 8;
    localparam int TREE_NODES   = 1 << NODE_W;
    localparam int DELTA_W      = 13;
    localparam int SAMPLE_W     = 16;
    localparam int CH_W         = 6;
    localparam int MAX_CHANNELS = 64;
    localparam int CNT_W        = 7;
    localparam int SKIP_W       = 5;
    localparam int RAW_WIDTH    = 12;
    localparam int RAW_CNT_W    = 4;
    localparam int MODE_W       = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [MODE_W-1:0] MODE_DATA    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BITS     = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0]         child_zero;
        logic [NODE_W-1:0]         child_one;
        logic signed [DELTA_W-1:0] node_delta;
    } node_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        node_t             node;
    } tree_wr_t;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_RAW  = 4'b0100,
        PH_WALK = 4'b1000
    } phase_t;

endpackage

// ===== hw/rtl/wfhd_tree_mem.sv =====
// ============================================================================
// wfhd_tree_mem
// Code tree node table: one write port, two registered read ports with
// write-through forwarding; entries never written read as leaves with delta 0.
// ============================================================================
module wfhd_tree_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wfhd_pkg::tree_wr_t        wr,
    input  logic [wfhd_pkg::NODE_W-1:0] rd_addr_zero,
    input  logic [wfhd_pkg::NODE_W-1:0] rd_addr_one,
    output wfhd_pkg::node_t           rd_zero,
    output wfhd_pkg::node_t           rd_one
);
    import wfhd_pkg::*;

    node_t                 mem [TREE_NODES];
    logic [TREE_NODES-1:0] valid_reg;
    node_t                 rd_zero_reg;
    node_t                 rd_one_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.node;
        end
    end

    // Reads track the walk every cycle; a same-cycle load is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr_zero))
        begin
            rd_zero_reg <= wr.node;
        end
        else if (!valid_reg[rd_addr_zero])
        begin
            rd_zero_reg <= '0;
        end
        else
        begin
            rd_zero_reg <= mem[rd_addr_zero];
        end

        if (wr.en && (wr.addr == rd_addr_one))
        begin
            rd_one_reg <= wr.node;
        end
        else if (!valid_reg[rd_addr_one])
        begin
            rd_one_reg <= '0;
        end
        else
        begin
            rd_one_reg <= mem[rd_addr_one];
        end
    end

    assign rd_zero = rd_zero_reg;
    assign rd_one  = rd_one_reg;

endmodule

// ===== hw/rtl/waveform_huffman_delta_decoder.sv =====
// ============================================================================
// waveform_huffman_delta_decoder
// Bit-serial raw / Huffman-delta sample decoder for interleaved channels.
// ============================================================================
// The block takes one beat per clock while the output is not stalled. An
// accepted beat is held in the input register and, once the output is free,
// is processed into the result register, which drives a result beat, if
// any, onto m_tvalid. Each beat is one stream bit, one tree node load or a
// restart; a tree walk moves one node per data beat. This step rate is set
// by the node table: the entries of both children of the current node are
// prefetched every cycle from its two read ports, so the leaf test of the
// next node needs no extra read. The previous sample of the current channel
// is likewise held ready from the per-channel sample store. Restart clears
// the channel history at once; the tree contents are kept until reset.
module waveform_huffman_delta_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write port
    input  logic                                cfg_we,
    input  logic [wfhd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfhd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_bit[0], node_index[8:1], child_zero[16:9], child_one[24:17],
    // node_delta[37:25], zero[39:38]
    input  logic [wfhd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  logic [wfhd_pkg::MODE_W-1:0]         s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_value[15:0], channel[21:16], zero[23:22]
    output logic [wfhd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // code_error[0]
    output logic                                m_tuser,
    // row_end
    output logic                                m_tlast
);
    import wfhd_pkg::*;

    // configuration
    logic [CNT_W-1:0]  channel_count_reg;
    logic [SKIP_W-1:0] skip_bits_reg;

    // input register
    logic              in_valid_reg;
    logic [MODE_W-1:0] in_mode_reg;
    logic              in_bit_reg;
    logic [NODE_W-1:0] in_idx_reg;
    node_t             in_node_reg;

    // decode state
    phase_t             phase_reg, phase_next;
    logic [SKIP_W-1:0]  skip_cnt_reg, skip_cnt_next;
    logic [RAW_CNT_W-1:0] raw_cnt_reg, raw_cnt_next;
    logic [RAW_WIDTH-1:0] raw_acc_reg, raw_acc_next;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    node_t              cur_reg, cur_next;
    node_t              root_reg, root_next;
    logic [CH_W-1:0]    chan_reg, chan_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [CH_W-1:0]            out_chan_reg;
    logic                       out_last_reg;
    logic                       out_err_reg;

    // previous sample store
    logic signed [SAMPLE_W-1:0] prev_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]    prev_valid_reg;
    logic signed [SAMPLE_W-1:0] prev_rd_reg;

    logic                       out_free;
    logic                       proc;
    tree_wr_t                   tree_wr;
    node_t                      rd_zero;
    node_t                      rd_one;
    phase_t                     eff_phase;
    logic [NODE_W-1:0]          child;
    node_t                      ent;
    logic                       ent_leaf;
    logic                       root_leaf;
    logic signed [DELTA_W-1:0]  delta_val;
    logic [SAMPLE_W:0]          sum_wide;
    logic signed [SAMPLE_W-1:0] sum_sat;
    logic [CNT_W-1:0]           eff_count;
    logic                       row_last;
    logic                       emit;
    logic                       emit_err;
    logic signed [SAMPLE_W-1:0] emit_val;
    logic                       prev_we;
    logic                       prev_clear;

    // ------------------------------------------------------------------
    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg            <= s_tuser;
            in_bit_reg             <= s_tdata[0];
            in_idx_reg             <= s_tdata[8:1];
            in_node_reg.child_zero <= s_tdata[16:9];
            in_node_reg.child_one  <= s_tdata[24:17];
            in_node_reg.node_delta <= s_tdata[37:25];
        end
    end

    // ------------------------------------------------------------------
    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CNT_W'(1);
            skip_bits_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SKIP_BITS:     skip_bits_reg     <= cfg_data[SKIP_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // node table
    wfhd_tree_mem u_tree (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (tree_wr),
        .rd_addr_zero (cur_next.child_zero),
        .rd_addr_one  (cur_next.child_one),
        .rd_zero      (rd_zero),
        .rd_one       (rd_one)
    );

    // ------------------------------------------------------------------
    // datapath helpers
    assign eff_phase = ((phase_reg == PH_SKIP) && (skip_cnt_reg >= skip_bits_reg))
                       ? PH_TYPE : phase_reg;
    assign child     = in_bit_reg ? cur_reg.child_one : cur_reg.child_zero;
    assign ent       = in_bit_reg ? rd_one : rd_zero;
    assign ent_leaf  = (ent.child_zero == '0) && (ent.child_one == '0);
    assign root_leaf = (root_reg.child_zero == '0) && (root_reg.child_one == '0);
    assign delta_val = (eff_phase == PH_TYPE) ? root_reg.node_delta : ent.node_delta;

    assign sum_wide = {prev_rd_reg[SAMPLE_W-1], prev_rd_reg}
                    + {{(SAMPLE_W+1-DELTA_W){delta_val[DELTA_W-1]}}, delta_val};

    always_comb
    begin
        if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1])
        begin
            sum_sat = sum_wide[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (channel_count_reg > CNT_W'(MAX_CHANNELS))
        begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_count = channel_count_reg;
        end
    end

    assign row_last = (({1'b0, chan_reg}) + CNT_W'(1)) >= eff_count;

    // ------------------------------------------------------------------
    // decode step
    always_comb
    begin
        phase_next    = phase_reg;
        skip_cnt_next = skip_cnt_reg;
        raw_cnt_next  = raw_cnt_reg;
        raw_acc_next  = raw_acc_reg;
        cursor_next   = cursor_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        emit          = 1'b0;
        emit_err      = 1'b0;
        emit_val      = '0;
        tree_wr       = '0;
        prev_clear    = 1'b0;

        if (proc)
        begin
            unique case (in_mode_reg)
                MODE_LOAD:
                begin
                    tree_wr.en   = 1'b1;
                    tree_wr.addr = in_idx_reg;
                    tree_wr.node = in_node_reg;
                    if (in_idx_reg == '0)
                    begin
                        root_next = in_node_reg;
                    end
                    if (in_idx_reg == cursor_reg)
                    begin
                        cur_next = in_node_reg;
                    end
                end
                MODE_RESTART:
                begin
                    phase_next    = PH_SKIP;
                    skip_cnt_next = '0;
                    raw_cnt_next  = '0;
                    raw_acc_next  = '0;
                    cursor_next   = '0;
                    cur_next      = root_reg;
                    prev_clear    = 1'b1;
                end
                MODE_DATA:
                begin
                    unique case (eff_phase)
                        PH_SKIP:
                        begin
                            skip_cnt_next = skip_cnt_reg + SKIP_W'(1);
                        end
                        PH_TYPE:
                        begin
                            if (!in_bit_reg)
                            begin
                                phase_next   = PH_RAW;
                                raw_cnt_next = '0;
                                raw_acc_next = '0;
                            end
                            else
                            begin
                                cursor_next = '0;
                                cur_next    = root_reg;
                                if (root_leaf)
                                begin
                                    phase_next = PH_TYPE;
                                    emit       = 1'b1;
                                    emit_val   = sum_sat;
                                end
                                else
                                begin
                                    phase_next = PH_WALK;
                                end
                            end
                        end
                        PH_RAW:
                        begin
                            raw_acc_next = {raw_acc_reg[RAW_WIDTH-2:0], in_bit_reg};
                            if (raw_cnt_reg == RAW_CNT_W'(RAW_WIDTH - 1))
                            begin
                                phase_next   = PH_TYPE;
                                raw_cnt_next = '0;
                                emit         = 1'b1;
                                emit_val     = {{(SAMPLE_W-RAW_WIDTH){1'b0}},
                                                raw_acc_reg[RAW_WIDTH-2:0], in_bit_reg};
                            end
                            else
                            begin
                                raw_cnt_next = raw_cnt_reg + RAW_CNT_W'(1);
                            end
                        end
                        PH_WALK:
                        begin
                            if (child == '0)
                            begin
                                // absent child: flag and resync on next type bit
                                phase_next  = PH_TYPE;
                                cursor_next = '0;
                                cur_next    = root_reg;
                                emit        = 1'b1;
                                emit_err    = 1'b1;
                            end
                            else if (ent_leaf)
                            begin
                                phase_next  = PH_TYPE;
                                cursor_next = '0;
                                cur_next    = root_reg;
                                emit        = 1'b1;
                                emit_val    = sum_sat;
                            end
                            else
                            begin
                                cursor_next = child;
                                cur_next    = ent;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign prev_we = emit && !emit_err;

    always_comb
    begin
        chan_next = chan_reg;
        if (prev_clear)
        begin
            chan_next = '0;
        end
        else if (prev_we)
        begin
            chan_next = row_last ? '0 : chan_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            skip_cnt_reg  <= '0;
            raw_cnt_reg   <= '0;
            raw_acc_reg   <= '0;
            cursor_reg    <= '0;
            cur_reg       <= '0;
            root_reg      <= '0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_cnt_reg  <= skip_cnt_next;
            raw_cnt_reg   <= raw_cnt_next;
            raw_acc_reg   <= raw_acc_next;
            cursor_reg    <= cursor_next;
            cur_reg       <= cur_next;
            root_reg      <= root_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            out_sample_reg <= emit_val;
            out_chan_reg   <= chan_reg;
            out_last_reg   <= row_last;
            out_err_reg    <= emit_err;
        end
    end

    // ------------------------------------------------------------------
    // previous sample store, read kept one step ahead at the next channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= '0;
        end
        else if (prev_clear)
        begin
            prev_valid_reg <= '0;
        end
        else if (prev_we)
        begin
            prev_valid_reg[chan_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[chan_reg] <= emit_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_clear)
        begin
            prev_rd_reg <= '0;
        end
        else if (prev_we && (chan_reg == chan_next))
        begin
            prev_rd_reg <= emit_val;
        end
        else if (!prev_valid_reg[chan_next])
        begin
            prev_rd_reg <= '0;
        end
        else
        begin
            prev_rd_reg <= prev_mem[chan_next];
        end
    end

    // ------------------------------------------------------------------
    // outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-CH_W-SAMPLE_W){1'b0}}, out_chan_reg, out_sample_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sim/tb_waveform_huffman_delta_decoder.sv =====
// ============================================================================
// tb_waveform_huffman_delta_decoder
// Self-checking bench for the bit-serial raw / Huffman-delta sample decoder.
// A queue-fed driver sends stream beats in random bursts while the result
// side stalls on its own pattern. Every accepted beat goes through a local
// decoder model whose samples are compared field by field with the output.
// Stimulus: a short directed opening, then phases of random register settings
// with random code trees, well-formed raw and coded samples, and some noise.
// ============================================================================
module tb_waveform_huffman_delta_decoder;

    import wfhd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1600;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic                      data_bit;
        logic [NODE_W-1:0]         node_index;
        logic [NODE_W-1:0]         child_zero;
        logic [NODE_W-1:0]         child_one;
        logic signed [DELTA_W-1:0] node_delta;
    } stream_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CH_W-1:0]            channel;
        logic                       row_end;
        logic                       code_error;
    } sample_t;

    typedef enum int {DELTAS_WIDE, DELTAS_NARROW, DELTAS_HIGH, DELTAS_LOW} delta_mix_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    waveform_huffman_delta_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // decoder model state
    phase_t                     dec_phase;
    logic [SKIP_W-1:0]          skip_ctr;
    logic [RAW_CNT_W-1:0]       raw_ctr;
    logic [RAW_WIDTH-1:0]       raw_acc;
    logic [NODE_W-1:0]          cursor;
    logic [CH_W-1:0]            chan_ctr;
    logic signed [SAMPLE_W-1:0] prev_samples [MAX_CHANNELS];
    node_t                      tree_nodes [TREE_NODES];
    logic [CNT_W-1:0]           chan_cfg = CNT_W'(1);
    logic [SKIP_W-1:0]          skip_cfg = '0;

    // stimulus side view of the tree, updated when a load is queued
    logic [NODE_W-1:0]          plan_zero [TREE_NODES];
    logic [NODE_W-1:0]          plan_one [TREE_NODES];
    delta_mix_t                 delta_style = DELTAS_WIDE;

    stream_item_t pending_items [$];
    sample_t      owed_samples [$];
    stream_item_t beat_on_bus;
    int           beats_queued   = 0;
    int           beats_accepted = 0;
    int           random_beats   = 0;
    int           results_seen   = 0;
    int           errors_seen    = 0;
    int           saturated_seen = 0;
    int           fault_count    = 0;
    int           idle_cycles    = 0;
    int           phase_count    = 0;
    logic         in_fire        = 1'b0;

    // sender bursts and receiver stall pattern
    bit           sender_gaps   = 1'b0;
    int           burst_left    = 1;
    int           gap_left      = 0;
    logic [15:0]  stall_pattern = 16'hFFFF;
    int           stall_len     = 1;
    int           stall_pos     = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic void clear_stream();
        dec_phase = PH_SKIP;
        skip_ctr  = '0;
        raw_ctr   = '0;
        raw_acc   = '0;
        cursor    = '0;
        chan_ctr  = '0;
        foreach (prev_samples[i]) prev_samples[i] = '0;
    endfunction

    function automatic bit is_leaf(input logic [NODE_W-1:0] node);
        return tree_nodes[node].child_zero == 0 && tree_nodes[node].child_one == 0;
    endfunction

    function automatic sample_t emit_sample(input logic signed [SAMPLE_W-1:0] value,
                                            input bit err);
        sample_t s;
        int      lanes;
        bit      last;
        lanes = (chan_cfg == 0) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
        last  = (int'(chan_ctr) + 1) >= lanes;
        s.sample_value = err ? '0 : value;
        s.channel      = chan_ctr;
        s.row_end      = last;
        s.code_error   = err;
        if (!err)
        begin
            prev_samples[chan_ctr] = value;
            chan_ctr = last ? '0 : chan_ctr + 1'b1;
        end
        return s;
    endfunction

    function automatic sample_t delta_sample(input logic [NODE_W-1:0] node);
        int sum;
        sum = int'(prev_samples[chan_ctr]) + int'(tree_nodes[node].node_delta);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        dec_phase = PH_TYPE;
        cursor    = '0;
        return emit_sample(sum[SAMPLE_W-1:0], 1'b0);
    endfunction

    // returns 1 when the beat completes a sample (or a code error)
    function automatic bit decode_beat(input stream_item_t it, output sample_t res);
        logic [NODE_W-1:0] child;
        res = '0;
        case (it.mode)
            MODE_LOAD:
            begin
                tree_nodes[it.node_index] = '{child_zero: it.child_zero,
                                              child_one:  it.child_one,
                                              node_delta: it.node_delta};
                return 1'b0;
            end
            MODE_RESTART:
            begin
                clear_stream();
                return 1'b0;
            end
            MODE_DATA: ;
            default: return 1'b0;
        endcase
        if (dec_phase == PH_SKIP)
        begin
            if (skip_ctr < skip_cfg)
            begin
                skip_ctr++;
                return 1'b0;
            end
            dec_phase = PH_TYPE;
        end
        if (dec_phase == PH_TYPE)
        begin
            if (!it.data_bit)
            begin
                dec_phase = PH_RAW;
                raw_ctr   = '0;
                raw_acc   = '0;
                return 1'b0;
            end
            cursor = '0;
            if (is_leaf('0))
            begin
                res = delta_sample('0);
                return 1'b1;
            end
            dec_phase = PH_WALK;
            return 1'b0;
        end
        if (dec_phase == PH_RAW)
        begin
            raw_acc = {raw_acc[RAW_WIDTH-2:0], it.data_bit};
            raw_ctr++;
            if (raw_ctr >= RAW_WIDTH)
            begin
                dec_phase = PH_TYPE;
                raw_ctr   = '0;
                res = emit_sample({{(SAMPLE_W-RAW_WIDTH){1'b0}}, raw_acc}, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        child = it.data_bit ? tree_nodes[cursor].child_one : tree_nodes[cursor].child_zero;
        if (child == 0)
        begin
            dec_phase = PH_TYPE;
            cursor    = '0;
            res = emit_sample('0, 1'b1);
            return 1'b1;
        end
        cursor = child;
        if (is_leaf(child))
        begin
            res = delta_sample(child);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic stream_item_t fresh_item(input logic [MODE_W-1:0] mode);
        stream_item_t it;
        it.mode       = mode;
        it.data_bit   = 1'($urandom_range(0, 1));
        it.node_index = NODE_W'($urandom_range(0, 255));
        it.child_zero = NODE_W'($urandom_range(0, 255));
        it.child_one  = NODE_W'($urandom_range(0, 255));
        it.node_delta = DELTA_W'($urandom_range(0, 8191));
        return it;
    endfunction

    function automatic logic signed [DELTA_W-1:0] pick_delta(input delta_mix_t style);
        int v;
        case (style)
            DELTAS_WIDE:   v = $urandom_range(0, 8191) - 4096;
            DELTAS_NARROW: v = $urandom_range(0, 16) - 8;
            DELTAS_HIGH:   v = $urandom_range(3900, 4095);
            default:       v = -$urandom_range(3900, 4096);
        endcase
        return v[DELTA_W-1:0];
    endfunction

    task automatic queue_item(input stream_item_t it);
        pending_items.push_back(it);
        beats_queued++;
        if (it.mode != MODE_UNUSED) random_beats++;
        if (it.mode == MODE_LOAD)
        begin
            plan_zero[it.node_index] = it.child_zero;
            plan_one[it.node_index]  = it.child_one;
        end
    endtask

    task automatic queue_data(input logic b);
        stream_item_t it;
        it = fresh_item(MODE_DATA);
        it.data_bit = b;
        queue_item(it);
    endtask

    task automatic queue_load(input int idx, input int c0, input int c1,
                              input logic signed [DELTA_W-1:0] d);
        stream_item_t it;
        it = fresh_item(MODE_LOAD);
        it.node_index = idx[NODE_W-1:0];
        it.child_zero = c0[NODE_W-1:0];
        it.child_one  = c1[NODE_W-1:0];
        it.node_delta = d;
        queue_item(it);
    endtask

    task automatic queue_restart(input int skip_count);
        queue_item(fresh_item(MODE_RESTART));
        repeat (skip_count) queue_data(1'($urandom_range(0, 1)));
    endtask

    task automatic queue_raw(input logic [RAW_WIDTH-1:0] value);
        queue_data(1'b0);
        for (int i = RAW_WIDTH - 1; i >= 0; i--) queue_data(value[i]);
    endtask

    // type bit 1, then random code bits down the planned tree to a leaf, an absent child or 20 steps
    task automatic queue_walk();
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] n;
        logic              b;
        int                steps;
        queue_data(1'b1);
        node  = '0;
        steps = 0;
        while ((plan_zero[node] != 0 || plan_one[node] != 0) && steps < 20)
        begin
            // occasional delta rewrite while a walk is in progress
            if ($urandom_range(0, 15) == 0)
            begin
                n = NODE_W'($urandom_range(0, 255));
                queue_load(n, plan_zero[n], plan_one[n], pick_delta(delta_style));
            end
            b = 1'($urandom_range(0, 1));
            queue_data(b);
            node = b ? plan_one[node] : plan_zero[node];
            steps++;
            if (node == 0) break;
        end
    endtask

    // full binary tree with random node numbers, root at node 0
    task automatic build_tree(input int leaves, input delta_mix_t style);
        int leaf_q [$];
        bit taken [TREE_NODES];
        int pair [2];
        int k;
        int parent;
        foreach (taken[i]) taken[i] = 1'b0;
        taken[0] = 1'b1;
        leaf_q.push_back(0);
        delta_style = style;
        while (leaf_q.size() < leaves)
        begin
            k = $urandom_range(0, leaf_q.size() - 1);
            parent = leaf_q[k];
            leaf_q.delete(k);
            for (int j = 0; j < 2; j++)
            begin
                do pair[j] = $urandom_range(1, TREE_NODES - 1); while (taken[pair[j]]);
                taken[pair[j]] = 1'b1;
                leaf_q.push_back(pair[j]);
            end
            queue_load(parent, pair[0], pair[1], pick_delta(style));
        end
        foreach (leaf_q[i]) queue_load(leaf_q[i], 0, 0, pick_delta(style));
    endtask

    task automatic queue_sample_or_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)
            queue_walk();
        else if (r < 88)
            case ($urandom_range(0, 9))
                0:       queue_raw('0);
                1:       queue_raw('1);
                default: queue_raw(RAW_WIDTH'($urandom_range(0, 4095)));
            endcase
        else if (r < 91)
            queue_data(1'($urandom_range(0, 1)));
        else if (r < 93)
            queue_item(fresh_item(MODE_UNUSED));
        else if (r < 95)
            queue_item(fresh_item(MODE_LOAD));
        else if (r < 97)
            queue_restart(skip_cfg);
        else
        begin
            // raw sample cut short: the following bits are parsed out of step
            queue_data(1'b0);
            repeat ($urandom_range(0, RAW_WIDTH - 1)) queue_data(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (beats_accepted != beats_queued || owed_samples.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_CHANNEL_COUNT) chan_cfg = val[CNT_W-1:0];
        else skip_cfg = val[SKIP_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // driver: input beats and result-side stalls change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        stream_item_t it;
        m_tready <= stall_pattern[stall_pos];
        stall_pos = (stall_pos + 1 >= stall_len) ? 0 : stall_pos + 1;
        if (!s_tvalid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                beat_on_bus = it;
                s_tdata  <= {2'b00, it.node_delta, it.child_one, it.child_zero,
                             it.node_index, it.data_bit};
                s_tuser  <= it.mode;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    if (!sender_gaps)
                        gap_left = 0;
                    else if ($urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(8, 30);
                    else
                        gap_left = $urandom_range(1, 4);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results, then run accepted beats through the model
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        sample_t got;
        sample_t want;
        sample_t made;
        logic    out_fire;
        out_fire = rst_n && m_tvalid === 1'b1 && m_tready === 1'b1;
        in_fire  = rst_n && s_tvalid && s_tready === 1'b1;
        if (out_fire)
        begin
            got.sample_value = m_tdata[SAMPLE_W-1:0];
            got.channel      = m_tdata[SAMPLE_W+CH_W-1:SAMPLE_W];
            got.row_end      = m_tlast;
            got.code_error   = m_tuser;
            results_seen++;
            if (owed_samples.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("[%0t] unexpected result: value %0d ch %0d last %0b err %0b",
                             $time, got.sample_value, got.channel, got.row_end,
                             got.code_error);
            end
            else
            begin
                want = owed_samples.pop_front();
                if (want.code_error) errors_seen++;
                else if (want.sample_value == 32767 || want.sample_value == -32768)
                    saturated_seen++;
                if (got.sample_value !== want.sample_value || got.channel !== want.channel ||
                    got.row_end !== want.row_end || got.code_error !== want.code_error)
                begin
                    fault_count++;
                    // fields shown as value/channel/row_end/code_error
                    if (fault_count <= 10)
                        $display("[%0t] mismatch: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 $time, want.sample_value, want.channel, want.row_end,
                                 want.code_error, got.sample_value, got.channel,
                                 got.row_end, got.code_error);
                end
            end
        end
        if (in_fire)
        begin
            beats_accepted++;
            if (decode_beat(beat_on_bus, made)) owed_samples.push_back(made);
        end
        if (in_fire || out_fire) idle_cycles = 0;
        else idle_cycles++;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: no beat moved for %0d cycles, %0d results still owed",
                 STALL_LIMIT, owed_samples.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stream_item_t odd_beat;
        int           chans;
        int           skips;
        int           mid_skip;
        int           leaves;
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
        foreach (plan_zero[i])
        begin
            plan_zero[i] = '0;
            plan_one[i]  = '0;
        end
        clear_stream();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening, reset settings: one channel, no skip
        odd_beat = '1;
        queue_item(odd_beat);                       // unknown mode, ignored
        queue_data(1'b1);                           // root is a leaf: sample at once
        queue_load(0, 0, 0, 13'sd4095);
        queue_data(1'b1);
        queue_load(0, 0, 0, -13'sd4096);
        queue_data(1'b1);
        queue_raw('1);
        queue_load(255, 0, 0, -13'sd4096);
        queue_load(0, 255, 0, 13'sd0);
        queue_data(1'b1);
        queue_data(1'b0);                           // walk to node 255
        queue_data(1'b1);
        queue_data(1'b1);                           // absent child
        queue_restart(0);

        random_beats = 0;
        mid_skip = -1;
        while (random_beats < ITEM_TARGET)
        begin
            wait_drained();
            case ($urandom_range(0, 7))
                0:       chans = 0;
                1:       chans = 1;
                2:       chans = MAX_CHANNELS;
                3:       chans = 127;
                4, 5:    chans = $urandom_range(2, 6);
                default: chans = $urandom_range(1, MAX_CHANNELS);
            endcase
            case ($urandom_range(0, 5))
                0:       skips = 0;
                1:       skips = 31;
                default: skips = $urandom_range(0, 8);
            endcase
            write_reg(CFG_CHANNEL_COUNT, chans);
            write_reg(CFG_SKIP_BITS, skips);

            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                stall_pattern = '1;
                stall_len     = 1;
            end
            else
            begin
                stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
                stall_len     = $urandom_range(2, 16);
            end

            if (phase_count == 0 || $urandom_range(0, 1) == 1)
            begin
                leaves = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(1, 8);
                build_tree(leaves, delta_mix_t'($urandom_range(0, 3)));
            end

            // a phase left mid-skip finishes the skip under the new count
            if (mid_skip >= 0)
            begin
                repeat ((skips > mid_skip) ? skips - mid_skip : 0)
                    queue_data(1'($urandom_range(0, 1)));
                mid_skip = -1;
            end
            else if ($urandom_range(0, 3) != 0)
                queue_restart(skips);

            repeat ($urandom_range(20, 90))
                if (random_beats < ITEM_TARGET) queue_sample_or_noise();

            if ($urandom_range(0, 7) == 0)
            begin
                mid_skip = $urandom_range(0, skips);
                queue_restart(mid_skip);
            end
            phase_count++;
        end

        wait_drained();
        $display("covered %0d beats over %0d register settings, %0d samples checked",
                 beats_accepted, phase_count, results_seen);
        $display("of those %0d code errors and %0d saturated sums; %0d faults",
                 errors_seen, saturated_seen, fault_count);
        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wfhd_pkg.sv
hw/rtl/wfhd_tree_mem.sv
hw/rtl/waveform_huffman_delta_decoder.sv
sim/tb_waveform_huffman_delta_decoder.sv
